[src/tlge_pkg.sv]
package tlge_pkg;

	// Field widths of the item and register formats.
	localparam int REQ_W     = 2;
	localparam int ROW_IDX_W = 5;
	localparam int DATA_W    = 32;
	localparam int ALIVE_W   = 11;
	localparam int GEN_W     = 16;
	localparam int CFG_W     = 6;
	localparam int CFG_IDX_W = 1;

	// Row counters must hold a register value plus two (the wrapped sweep).
	localparam int CNT_W = CFG_W + 1;

	// Neighbor sums go up to eight.
	localparam int NBR_W = 4;

	// Default grid capacity and reset sizes.
	localparam int DEF_MAX_ROWS = 32;
	localparam int DEF_MAX_COLS = 32;
	localparam logic [CFG_W-1:0] RESET_ROWS = 6'd30;
	localparam logic [CFG_W-1:0] RESET_COLS = 6'd32;
	localparam logic [GEN_W-1:0] GEN_RESET  = 16'd1;

	// Depth of the command and result queues.
	localparam int QUEUE_DEPTH = 2;

	// Life rule B3/S23.
	localparam logic [NBR_W-1:0] BIRTH_N   = 4'd3;
	localparam logic [NBR_W-1:0] SURVIVE_N = 4'd2;

	// Request type codes on the input port.
	localparam logic [REQ_W-1:0] REQ_WRITE = 2'd0;
	localparam logic [REQ_W-1:0] REQ_STEP  = 2'd1;
	localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 1'd1;

	// Decoded operation handed from the front end to the engine.
	typedef enum logic [1:0] {
		OP_WRITE,
		OP_STEP,
		OP_READ,
		OP_NONE
	} op_t;

	// Engine sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_SWEEP,
		ST_DRAIN
	} state_t;

	typedef struct packed {
		logic [REQ_W-1:0]     req_type;
		logic [ROW_IDX_W-1:0] row_index;
		logic [DATA_W-1:0]    row_bits;
	} req_t;

	typedef struct packed {
		logic [DATA_W-1:0]  read_bits;
		logic [ALIVE_W-1:0] alive_count;
		logic [GEN_W-1:0]   generation;
	} rsp_t;

	typedef struct packed {
		op_t                  op;
		logic [ROW_IDX_W-1:0] row;
		logic [DATA_W-1:0]    bits;
	} cmd_t;

	typedef struct packed {
		logic [CFG_W-1:0] grid_rows;
		logic [CFG_W-1:0] grid_cols;
	} cfg_t;

endpackage

[src/tlge_ram.sv]
module tlge_ram import tlge_pkg::*; #(
	parameter int WIDTH = DEF_MAX_COLS,
	parameter int DEPTH = DEF_MAX_ROWS
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[src/tlge_fifo.sv]
module tlge_fifo import tlge_pkg::*; #(
	parameter int WIDTH = DATA_W,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PW = $clog2(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW:0]      wp_q;
	logic [PW:0]      rp_q;

	// Pointers carry one extra wrap bit to tell full from empty.
	assign empty = (wp_q == rp_q);
	assign full  = (wp_q[PW] != rp_q[PW]) && (wp_q[PW-1:0] == rp_q[PW-1:0]);
	assign rdata = mem_q[rp_q[PW-1:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
		end else begin
			if (push && !full) begin
				wp_q <= wp_q + 1'b1;
			end
			if (pop && !empty) begin
				rp_q <= rp_q + 1'b1;
			end
		end
	end

	// Entry storage needs no reset.
	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wp_q[PW-1:0]] <= wdata;
		end
	end

endmodule

[src/tlge_front.sv]
module tlge_front import tlge_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  req_t req,
	output cmd_t cmd,
	output logic cmd_empty,
	input  logic cmd_pop
);

	cmd_t             cmd_in;
	logic [$bits(cmd_t)-1:0] cmd_raw;

	// Decode the request type into an engine operation.
	always_comb begin
		cmd_in.row  = req.row_index;
		cmd_in.bits = req.row_bits;
		case (req.req_type)
			REQ_WRITE: cmd_in.op = OP_WRITE;
			REQ_STEP:  cmd_in.op = OP_STEP;
			REQ_READ:  cmd_in.op = OP_READ;
			default:   cmd_in.op = OP_NONE;
		endcase
	end

	// Decoded commands wait here until the engine takes them.
	tlge_fifo #(
		.WIDTH($bits(cmd_t)),
		.DEPTH(QUEUE_DEPTH)
	) u_cmd_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (cmd_in),
		.full  (full),
		.pop   (cmd_pop),
		.rdata (cmd_raw),
		.empty (cmd_empty)
	);

	assign cmd = cmd_t'(cmd_raw);

endmodule

[src/tlge_back.sv]
module tlge_back import tlge_pkg::*; #(
	parameter int MAX_ROWS = DEF_MAX_ROWS,
	parameter int MAX_COLS = DEF_MAX_COLS
) (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  cmd_t cmd,
	input  logic cmd_empty,
	output logic cmd_pop,
	output rsp_t res,
	output logic res_push,
	input  logic res_full
);

	localparam int AW = $clog2(MAX_ROWS > 1 ? MAX_ROWS : 2);
	localparam int XW = $clog2(MAX_COLS > 1 ? MAX_COLS : 2);

	state_t st_q, st_d;

	logic                sel_q;
	logic [GEN_W-1:0]    gen_q;
	logic [ALIVE_W-1:0]  alive_q;
	logic [ALIVE_W-1:0]  acc_q;
	logic [MAX_ROWS-1:0] vld_q [2];
	logic [CNT_W-1:0]    k_q;
	logic                rd_hit_q;

	// Sweep pipeline: read issue stage and row window stage.
	logic                iss_s1;
	logic [CNT_W-1:0]    k_s1;
	logic                rv_s1;
	logic [MAX_COLS-1:0] win_up_q, win_mid_q, win_dn_q;
	logic                win_ok_q;
	logic [CNT_W-1:0]    r_q;

	logic [CNT_W-1:0]    rows_c;
	logic [CNT_W-1:0]    rows_p1;
	logic [CFG_W-1:0]    cols_c;
	logic [MAX_COLS-1:0] colmask;
	logic [CNT_W-1:0]    row_ext;
	logic                row_hit;
	logic [CNT_W-1:0]    sweep_row;

	logic                wr_item, rd_item, clr_dst, iss, finish;

	logic [AW-1:0]       rd_addr, wr_addr;
	logic [MAX_COLS-1:0] wr_data;
	logic [1:0]          ram_we;
	logic [MAX_COLS-1:0] ram_rdata [2];
	logic [MAX_COLS-1:0] rdata_src;
	logic [MAX_COLS-1:0] src_word;

	logic [MAX_COLS-1:0] row_w [3];
	logic [MAX_COLS-1:0] lft_w [3];
	logic [MAX_COLS-1:0] rgt_w [3];
	logic [MAX_COLS-1:0] next_row;
	logic [XW-1:0]       last_idx;

	// Active grid size, clamped to the storage.
	always_comb begin
		if (cfg.grid_rows == '0) begin
			rows_c = CNT_W'(1);
		end else if (CNT_W'(cfg.grid_rows) > CNT_W'(MAX_ROWS)) begin
			rows_c = CNT_W'(MAX_ROWS);
		end else begin
			rows_c = CNT_W'(cfg.grid_rows);
		end
		if (cfg.grid_cols == '0) begin
			cols_c = CFG_W'(1);
		end else if (cfg.grid_cols > CFG_W'(MAX_COLS)) begin
			cols_c = CFG_W'(MAX_COLS);
		end else begin
			cols_c = cfg.grid_cols;
		end
	end

	assign rows_p1 = rows_c + CNT_W'(1);

	for (genvar c = 0; c < MAX_COLS; c++) begin : g_mask
		assign colmask[c] = (CFG_W'(c) < cols_c);
	end

	// Addressed row of a read or write command.
	assign row_ext = CNT_W'(cmd.row);
	assign row_hit = (row_ext < rows_c);

	// The sweep reads the last row, then every row, then row zero again,
	// so that each row is seen between both of its wrapped neighbors.
	always_comb begin
		if (k_q == '0) begin
			sweep_row = rows_c - CNT_W'(1);
		end else if (k_q == rows_p1) begin
			sweep_row = '0;
		end else begin
			sweep_row = k_q - CNT_W'(1);
		end
	end

	// Next state of the sequencer.
	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_IDLE: begin
				if (rd_item) begin
					st_d = ST_READ;
				end else if (clr_dst) begin
					st_d = ST_SWEEP;
				end
			end
			ST_READ: begin
				st_d = ST_IDLE;
			end
			ST_SWEEP: begin
				if (k_q == rows_p1) begin
					st_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (finish) begin
					st_d = ST_IDLE;
				end
			end
			default: begin
				st_d = ST_IDLE;
			end
		endcase
	end

	// Sequencer outputs and the result item.
	always_comb begin
		cmd_pop  = 1'b0;
		res_push = 1'b0;
		wr_item  = 1'b0;
		rd_item  = 1'b0;
		clr_dst  = 1'b0;
		iss      = 1'b0;
		finish   = 1'b0;
		res.read_bits   = '0;
		res.alive_count = alive_q;
		res.generation  = gen_q;
		case (st_q)
			ST_IDLE: begin
				if (!cmd_empty && !res_full) begin
					cmd_pop = 1'b1;
					case (cmd.op)
						OP_WRITE: begin
							wr_item  = 1'b1;
							res_push = 1'b1;
						end
						OP_READ: begin
							rd_item = 1'b1;
						end
						OP_STEP: begin
							clr_dst = 1'b1;
						end
						default: begin
							res_push = 1'b1;
						end
					endcase
				end
			end
			ST_READ: begin
				res_push = 1'b1;
				if (rd_hit_q) begin
					res.read_bits = DATA_W'(rdata_src & colmask);
				end
			end
			ST_SWEEP: begin
				iss = 1'b1;
			end
			ST_DRAIN: begin
				if (!iss_s1 && !win_ok_q) begin
					finish   = 1'b1;
					res_push = 1'b1;
					res.alive_count = acc_q;
					res.generation  = gen_q + GEN_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

	// Memory ports: commands use the current grid, the sweep writes the other.
	assign rd_addr = rd_item ? row_ext[AW-1:0] : sweep_row[AW-1:0];
	assign wr_addr = wr_item ? row_ext[AW-1:0] : r_q[AW-1:0];
	assign wr_data = wr_item ? (cmd.bits[MAX_COLS-1:0] & colmask) : next_row;

	for (genvar b = 0; b < 2; b++) begin : g_grid
		assign ram_we[b] = (wr_item && row_hit && (sel_q == 1'(b))) ||
		                   (win_ok_q && (sel_q != 1'(b)));

		tlge_ram #(
			.WIDTH(MAX_COLS),
			.DEPTH(MAX_ROWS)
		) u_ram (
			.clk  (clk),
			.we   (ram_we[b]),
			.waddr(wr_addr),
			.wdata(wr_data),
			.raddr(rd_addr),
			.rdata(ram_rdata[b])
		);
	end

	assign rdata_src = sel_q ? ram_rdata[1] : ram_rdata[0];
	assign src_word  = rv_s1 ? rdata_src : '0;

	// Column neighbors with wraparound at the active width.
	assign row_w[0] = win_up_q;
	assign row_w[1] = win_mid_q;
	assign row_w[2] = win_dn_q;
	assign last_idx = XW'(cols_c - CFG_W'(1));

	for (genvar i = 0; i < 3; i++) begin : g_win
		for (genvar c = 0; c < MAX_COLS; c++) begin : g_col
			if (c == 0) begin : g_first
				assign lft_w[i][c] = row_w[i][last_idx];
			end else begin : g_inner
				assign lft_w[i][c] = row_w[i][c-1];
			end
			if (c == MAX_COLS - 1) begin : g_last
				assign rgt_w[i][c] = row_w[i][0];
			end else begin : g_body
				assign rgt_w[i][c] = (CFG_W'(c + 1) == cols_c) ? row_w[i][0] : row_w[i][c+1];
			end
		end
	end

	// Neighbor count and the B3/S23 rule for every cell of the middle row.
	for (genvar c = 0; c < MAX_COLS; c++) begin : g_cell
		logic [NBR_W-1:0] nbr;
		assign nbr = {3'b000, lft_w[0][c]} + {3'b000, row_w[0][c]} + {3'b000, rgt_w[0][c]} +
		             {3'b000, lft_w[1][c]} + {3'b000, rgt_w[1][c]} +
		             {3'b000, lft_w[2][c]} + {3'b000, row_w[2][c]} + {3'b000, rgt_w[2][c]};
		assign next_row[c] = colmask[c] &&
		                     ((nbr == BIRTH_N) || (row_w[1][c] && (nbr == SURVIVE_N)));
	end

	// Control state, counters and grid bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_IDLE;
			sel_q    <= 1'b0;
			gen_q    <= GEN_RESET;
			alive_q  <= '0;
			acc_q    <= '0;
			vld_q[0] <= '0;
			vld_q[1] <= '0;
			k_q      <= '0;
			iss_s1   <= 1'b0;
			win_ok_q <= 1'b0;
			rd_hit_q <= 1'b0;
		end else begin
			st_q     <= st_d;
			iss_s1   <= iss;
			win_ok_q <= iss_s1 && (k_s1 >= CNT_W'(2));
			if (clr_dst) begin
				k_q            <= '0;
				acc_q          <= '0;
				vld_q[~sel_q]  <= '0;
			end else if (iss) begin
				k_q <= k_q + CNT_W'(1);
			end
			if (rd_item) begin
				rd_hit_q <= row_hit && vld_q[sel_q][row_ext[AW-1:0]];
			end
			if (wr_item && row_hit) begin
				vld_q[sel_q][row_ext[AW-1:0]] <= 1'b1;
			end
			if (win_ok_q) begin
				vld_q[~sel_q][r_q[AW-1:0]] <= 1'b1;
				acc_q <= acc_q + ALIVE_W'($countones(win_mid_q & colmask));
			end
			if (finish) begin
				vld_q[sel_q] <= '0;
				sel_q        <= ~sel_q;
				gen_q        <= gen_q + GEN_W'(1);
				alive_q      <= acc_q;
			end
		end
	end

	// Sweep data path: read stage and the three-row window.
	always_ff @(posedge clk) begin
		k_s1  <= k_q;
		rv_s1 <= vld_q[sel_q][sweep_row[AW-1:0]];
		r_q   <= k_s1 - CNT_W'(2);
		if (iss_s1) begin
			win_up_q  <= win_mid_q;
			win_mid_q <= win_dn_q;
			win_dn_q  <= src_word;
		end
	end

	// The engine takes no new command while one is in progress.
	a_busy_no_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != ST_IDLE) |-> !cmd_pop)
		else $error("command taken while the engine is busy");

	// Every row produced by the sweep lies within the active rows.
	a_row_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		win_ok_q |-> (r_q < rows_c))
		else $error("sweep produced a row outside the active grid");

	// Finishing a step swaps the current grid.
	a_swap: assert property (@(posedge clk) disable iff (!arst_n)
		finish |=> (sel_q != $past(sel_q)))
		else $error("grid select did not toggle after a step");

	// A result is only pushed where the result queue has room.
	a_res_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result pushed into a full queue");

endmodule

[src/toroidal_life_generation_engine_core.sv]
// Toroidal B3/S23 Life engine with two grid buffers of MAX_ROWS rows by MAX_COLS
// columns. Items enter through a small command queue and results leave through a
// small result queue, so both sides may stall independently; every item gives
// exactly one result. Inside the engine a row write or an unknown request gives
// its result from the idle state, while a row read passes through a read
// state (the grid memory has a registered read port). A generation step sweeps
// the source grid through that single read port, one row per cycle, reading the
// rows wrapped at both ends, and sets the rate of the block. Per-row valid flags
// track the grids; reset clears them at once, so no clearing pass follows reset.
// Grid size registers must be written only while idle; the block does not check.
module toroidal_life_generation_engine_core import tlge_pkg::*; #(
	parameter int MAX_ROWS = DEF_MAX_ROWS,
	parameter int MAX_COLS = DEF_MAX_COLS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  req_t                 req,
	output logic                 empty,
	input  logic                 pop,
	output rsp_t                 rsp,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	cfg_t                    cfg_q;
	cmd_t                    cmd;
	logic                    cmd_empty;
	logic                    cmd_pop;
	rsp_t                    res;
	logic                    res_push;
	logic                    res_full;
	logic [$bits(rsp_t)-1:0] rsp_raw;

	// Grid size registers.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.grid_rows <= RESET_ROWS;
			cfg_q.grid_cols <= RESET_COLS;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_GRID_ROWS: cfg_q.grid_rows <= cfg_data;
				REG_GRID_COLS: cfg_q.grid_cols <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Front end: request decode and command queue.
	tlge_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.req      (req),
		.cmd      (cmd),
		.cmd_empty(cmd_empty),
		.cmd_pop  (cmd_pop)
	);

	// Engine: grid memories and generation sweep.
	tlge_back #(
		.MAX_ROWS(MAX_ROWS),
		.MAX_COLS(MAX_COLS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.cmd      (cmd),
		.cmd_empty(cmd_empty),
		.cmd_pop  (cmd_pop),
		.res      (res),
		.res_push (res_push),
		.res_full (res_full)
	);

	// Result queue facing the consumer.
	tlge_fifo #(
		.WIDTH($bits(rsp_t)),
		.DEPTH(QUEUE_DEPTH)
	) u_res_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.wdata (res),
		.full  (res_full),
		.pop   (pop),
		.rdata (rsp_raw),
		.empty (empty)
	);

	assign rsp = rsp_t'(rsp_raw);

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

import tlge_pkg::*;

// Tracks the expected Life engine state and checks every result item in order.
class life_scoreboard;
	logic [DATA_W-1:0]  grid [2][32];
	bit                 sel;
	logic [GEN_W-1:0]   gen;
	logic [ALIVE_W-1:0] alive;
	logic [CFG_W-1:0]   rows_reg;
	logic [CFG_W-1:0]   cols_reg;
	rsp_t               due [$];
	int                 mismatches;
	int                 checked;

	function new();
		for (int b = 0; b < 2; b++) begin
			for (int r = 0; r < 32; r++) begin
				grid[b][r] = '0;
			end
		end
		sel = 1'b0;
		gen = GEN_RESET;
		alive = '0;
		rows_reg = RESET_ROWS;
		cols_reg = RESET_COLS;
		mismatches = 0;
		checked = 0;
	endfunction

	// Active row count, with out-of-range register values clamped.
	function int eff_rows();
		if (rows_reg == 0) return 1;
		if (rows_reg > 32) return 32;
		return int'(rows_reg);
	endfunction

	function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
		if (idx == REG_GRID_ROWS) begin
			rows_reg = value;
		end else begin
			cols_reg = value;
		end
	endfunction

	function int pending();
		return due.size();
	endfunction

	// Applies one accepted item to the predicted state and queues its result.
	function void note_item(req_t item);
		int nr, nc, r, c, rm, rp, cm, cp, n, count;
		bit keep;
		logic [DATA_W-1:0] mask;
		rsp_t want;
		nr = eff_rows();
		nc = (cols_reg == 0) ? 1 : ((cols_reg > 32) ? 32 : int'(cols_reg));
		mask = (nc == 32) ? '1 : ((32'd1 << nc) - 32'd1);
		want.read_bits = '0;
		case (item.req_type)
			REQ_WRITE: begin
				if (item.row_index < nr) grid[sel][item.row_index] = item.row_bits & mask;
			end
			REQ_STEP: begin
				count = 0;
				for (r = 0; r < 32; r++) grid[!sel][r] = '0;
				// Sweep the active region on a torus; tiny grids count wrapped
				// neighbors as often as they occur, the cell itself included.
				for (r = 0; r < nr; r++) begin
					rm = (r == 0) ? nr - 1 : r - 1;
					rp = (r + 1 == nr) ? 0 : r + 1;
					for (c = 0; c < nc; c++) begin
						cm = (c == 0) ? nc - 1 : c - 1;
						cp = (c + 1 == nc) ? 0 : c + 1;
						n = int'(grid[sel][rm][cm]) + int'(grid[sel][rm][c]) +
							int'(grid[sel][rm][cp]) + int'(grid[sel][r][cm]) +
							int'(grid[sel][r][cp]) + int'(grid[sel][rp][cm]) +
							int'(grid[sel][rp][c]) + int'(grid[sel][rp][cp]);
						if (grid[sel][r][c]) begin
							count++;
							keep = (n == SURVIVE_N) || (n == BIRTH_N);
						end else begin
							keep = (n == BIRTH_N);
						end
						if (keep) grid[!sel][r][c] = 1'b1;
					end
				end
				for (r = 0; r < 32; r++) grid[sel][r] = '0;
				sel = !sel;
				gen = gen + 1'b1;
				alive = count[ALIVE_W-1:0];
			end
			REQ_READ: begin
				if (item.row_index < nr) want.read_bits = grid[sel][item.row_index] & mask;
			end
			default: begin
			end
		endcase
		want.alive_count = alive;
		want.generation = gen;
		due.push_back(want);
	endfunction

	// Compares one result item with the oldest expectation.
	function void check_result(rsp_t got);
		rsp_t want;
		if (due.size() == 0) begin
			$error("Result item arrived with no item waiting for it");
			mismatches++;
			return;
		end
		want = due.pop_front();
		checked++;
		if (got.read_bits !== want.read_bits) begin
			$error("read_bits: expected %h, got %h", want.read_bits, got.read_bits);
			mismatches++;
		end
		if (got.alive_count !== want.alive_count) begin
			$error("alive_count: expected %0d, got %0d", want.alive_count, got.alive_count);
			mismatches++;
		end
		if (got.generation !== want.generation) begin
			$error("generation: expected %0d, got %0d", want.generation, got.generation);
			mismatches++;
		end
	endfunction
endclass

module testbench;

	localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 push = 1'b0;
	logic                 full;
	req_t                 req = '0;
	logic                 empty;
	logic                 pop = 1'b0;
	rsp_t                 rsp;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;

	life_scoreboard sb = new();

	bit no_gaps = 1'b0;
	int sent_total = 0;
	int n_write = 0;
	int n_step = 0;
	int n_read = 0;
	int n_unknown = 0;
	int n_sizes = 1;

	toroidal_life_generation_engine_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.req(req),
		.empty(empty),
		.pop(pop),
		.rsp(rsp),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Idle lengths: mostly none or short, now and then long.
	function automatic int pick_gap();
		int roll;
		if (no_gaps) return 0;
		roll = $urandom_range(0, 99);
		if (roll < 60) return 0;
		if (roll < 85) return $urandom_range(1, 3);
		if (roll < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Row contents of varied density.
	function automatic logic [DATA_W-1:0] random_cells();
		case ($urandom_range(0, 3))
			0: return $urandom();
			1: return $urandom() & $urandom();
			2: return $urandom() & $urandom() & $urandom();
			default: return $urandom() | $urandom();
		endcase
	endfunction

	// Offers one item, waits until it is taken, then idles at random.
	task automatic send_item(input logic [REQ_W-1:0] kind, input int row,
		input logic [DATA_W-1:0] bits);
		req_t item;
		int gap;
		item.req_type = kind;
		item.row_index = row[ROW_IDX_W-1:0];
		item.row_bits = bits;
		@(negedge clk);
		push <= 1'b1;
		req <= item;
		do @(posedge clk); while (full);
		sb.note_item(item);
		sent_total++;
		case (kind)
			REQ_WRITE: n_write++;
			REQ_STEP: n_step++;
			REQ_READ: n_read++;
			default: n_unknown++;
		endcase
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			push <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// Holds the sender back until every queued result has been taken.
	task automatic wait_results_drained();
		@(negedge clk);
		push <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, value);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Random traffic: mostly seeded patterns left to evolve, with some noise.
	task automatic run_phase(input int n_items);
		int start, nr, first, last, r;
		start = sent_total;
		nr = sb.eff_rows();
		while (sent_total - start < n_items) begin
			if ($urandom_range(0, 9) < 7) begin
				if ($urandom_range(0, 2) == 0) begin
					first = $urandom_range(0, nr - 1);
					last = $urandom_range(first, nr - 1);
				end else begin
					first = 0;
					last = nr - 1;
				end
				for (r = first; r <= last; r++) send_item(REQ_WRITE, r, random_cells());
				repeat ($urandom_range(1, 8)) begin
					send_item(REQ_STEP, $urandom_range(0, 31), $urandom());
					if ($urandom_range(0, 1)) begin
						send_item(REQ_READ, ($urandom_range(0, 4) == 0) ?
							$urandom_range(0, 31) : $urandom_range(0, nr - 1), $urandom());
					end
				end
			end else begin
				repeat ($urandom_range(1, 4)) begin
					send_item(REQ_W'($urandom_range(0, 3)), $urandom_range(0, 31),
						random_cells());
				end
			end
		end
	endtask

	// Result side: takes results with random stalls between them.
	initial begin : result_sink
		int stall;
		stall = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			pop <= (stall == 0);
			if (stall > 0) stall--;
			@(posedge clk);
			if (pop && !empty) begin
				sb.check_result(rsp);
				stall = pick_gap();
			end
		end
	end

	initial begin : stimulus
		int p, nr, nc;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		// Directed items at the reset size of 30 rows by 32 columns.
		send_item(REQ_READ, 0, $urandom());
		send_item(REQ_READ, 31, $urandom());
		send_item(REQ_STEP, 0, $urandom());
		send_item(REQ_WRITE, 0, 32'hFFFF_FFFF);
		send_item(REQ_WRITE, 29, 32'h8000_0001);
		send_item(REQ_WRITE, 30, 32'hFFFF_FFFF);
		send_item(REQ_WRITE, 31, 32'hFFFF_FFFF);
		send_item(REQ_READ, 0, '0);
		send_item(REQ_READ, 29, '0);
		send_item(REQ_READ, 30, '1);
		send_item(REQ_UNKNOWN, 5, $urandom());
		// A glider in rows 5 to 7.
		send_item(REQ_WRITE, 5, 32'h0000_0004);
		send_item(REQ_WRITE, 6, 32'h0000_0008);
		send_item(REQ_WRITE, 7, 32'h0000_000E);
		send_item(REQ_STEP, 31, '1);
		send_item(REQ_READ, 5, '0);
		send_item(REQ_READ, 6, '0);
		send_item(REQ_READ, 7, '0);
		send_item(REQ_READ, 8, '0);
		send_item(REQ_STEP, 0, '0);
		send_item(REQ_READ, 0, '0);
		send_item(REQ_READ, 29, '0);
		send_item(REQ_READ, 1, '0);
		wait_results_drained();

		// Each phase sets a new grid size while idle, then runs random traffic.
		for (p = 0; p < 14; p++) begin
			case (p)
				0: begin nr = 1; nc = 1; end
				1: begin nr = 2; nc = 2; end
				2: begin nr = 0; nc = 0; end
				3: begin nr = 63; nc = 63; end
				4: begin nr = 32; nc = 32; end
				5: begin nr = 1; nc = 32; end
				6: begin nr = 32; nc = 1; end
				7: begin nr = 33; nc = 2; end
				default: begin
					nr = $urandom_range(0, 63);
					nc = $urandom_range(0, 63);
				end
			endcase
			write_reg(REG_GRID_ROWS, nr[CFG_W-1:0]);
			write_reg(REG_GRID_COLS, nc[CFG_W-1:0]);
			n_sizes++;
			no_gaps = ($urandom_range(0, 3) == 0);
			run_phase(40);
			wait_results_drained();
		end
		no_gaps = 1'b0;

		repeat (64) @(posedge clk);
		$display("Sent %0d items: %0d row writes, %0d steps, %0d row reads, %0d unknown.",
			sent_total, n_write, n_step, n_read, n_unknown);
		$display("Checked %0d results across %0d grid sizes, from 1x1 to clamped 32x32.",
			sb.checked, n_sizes);
		if (sb.mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	// Watchdog for a stalled handshake.
	initial begin : watchdog
		#10_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule
